FILE: design/mbf_pkg.sv
// Package for the Modbus RTU request framer: microcode word layout, the
// program ROM contents and the CRC-16 byte update. Depends on nothing.
package mbf_pkg;

  localparam int unsigned PcW     = 4;
  localparam int unsigned ProgLen = 13;

  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  localparam logic [7:0] QtyHi     = 8'h00;
  localparam logic [7:0] QtyLo     = 8'h01;
  localparam logic [7:0] ByteCount = 8'h02;

  // Where the byte emitted by a microcode step comes from.
  typedef enum logic [3:0] {
    SRC_SLAVE,
    SRC_FUNC,
    SRC_ADDR_HI,
    SRC_ADDR_LO,
    SRC_CV_HI,
    SRC_CV_LO,
    SRC_QTY_HI,
    SRC_QTY_LO,
    SRC_BYTE_CNT,
    SRC_CRC_LO,
    SRC_CRC_HI
  } byte_src_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_WRITE,
    JMP_ALWAYS
  } jump_e;

  typedef struct packed {
    byte_src_e      src;
    logic           last;
    jump_e          jump;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic           busy;
    logic [PcW-1:0] pc;
  } seq_status_t;

  // Program: the common header, then either the read tail or the write tail,
  // both ending in the two CRC steps.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    w = '{src: SRC_CRC_HI, last: 1'b1, jump: JMP_NONE, target: '0};
    unique case (pc)
      4'd0:  w = '{src: SRC_SLAVE,    last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd1:  w = '{src: SRC_FUNC,     last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd2:  w = '{src: SRC_ADDR_HI,  last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd3:  w = '{src: SRC_ADDR_LO,  last: 1'b0, jump: JMP_WRITE,  target: 4'd6};
      4'd4:  w = '{src: SRC_CV_HI,    last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd5:  w = '{src: SRC_CV_LO,    last: 1'b0, jump: JMP_ALWAYS, target: 4'd11};
      4'd6:  w = '{src: SRC_QTY_HI,   last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd7:  w = '{src: SRC_QTY_LO,   last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd8:  w = '{src: SRC_BYTE_CNT, last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd9:  w = '{src: SRC_CV_HI,    last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd10: w = '{src: SRC_CV_LO,    last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd11: w = '{src: SRC_CRC_LO,   last: 1'b0, jump: JMP_NONE,   target: 4'd0};
      4'd12: w = '{src: SRC_CRC_HI,   last: 1'b1, jump: JMP_NONE,   target: 4'd0};
      default: w = '{src: SRC_CRC_HI, last: 1'b1, jump: JMP_NONE,   target: 4'd0};
    endcase
    return w;
  endfunction

  // Bitwise reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mbf_if.sv
// Handshake interfaces for the request and frame byte channels.
// Depends on nothing.
interface mbf_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  slave_addr;
  logic [7:0]  function_code;
  logic [15:0] reg_addr;
  logic [15:0] count_or_value;

  modport source (output valid, mode, slave_addr, function_code, reg_addr, count_or_value,
                  input ready);
  modport sink (input valid, mode, slave_addr, function_code, reg_addr, count_or_value,
                output ready);
endinterface

interface mbf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

FILE: design/mbf_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on mbf_pkg.
module mbf_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                mode_i,
  input  logic                advance_i,
  output mbf_pkg::uword_t     uword_o,
  output mbf_pkg::seq_status_t status_o
);

  logic [mbf_pkg::PcW-1:0] pc_q, pc_d;
  logic                    busy_q, busy_d;
  logic                    mode_q, mode_d;
  mbf_pkg::uword_t         uw;
  logic                    take_jump;

  assign uw = mbf_pkg::ucode(pc_q);

  always_comb begin
    unique case (uw.jump)
      mbf_pkg::JMP_WRITE:  take_jump = mode_q;
      mbf_pkg::JMP_ALWAYS: take_jump = 1'b1;
      default:             take_jump = 1'b0;
    endcase
  end

  // A new request may start in the same cycle as the last step of the
  // previous one; the start then wins.
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    mode_d = mode_q;
    priority if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
      mode_d = mode_i;
    end else if (advance_i) begin
      if (uw.last) begin
        busy_d = 1'b0;
      end else begin
        pc_d = take_jump ? uw.target : pc_q + 1'b1;
      end
    end else begin
      pc_d   = pc_q;
      busy_d = busy_q;
      mode_d = mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
      mode_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
      mode_q <= mode_d;
    end
  end

  assign uword_o  = uw;
  assign status_o = '{busy: busy_q, pc: pc_q};

endmodule

FILE: design/mbf_datapath.sv
// Datapath: request field registers, CRC accumulator, byte select and the
// output register. Depends on mbf_pkg.
module mbf_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [7:0]      slave_addr_i,
  input  logic [7:0]      function_code_i,
  input  logic [15:0]     reg_addr_i,
  input  logic [15:0]     count_or_value_i,
  input  logic            advance_i,
  input  mbf_pkg::uword_t uword_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o
);

  logic [7:0]  slave_q, func_q;
  logic [15:0] addr_q, cv_q;
  logic [15:0] crc_q, crc_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [7:0]  sel_byte;
  logic        is_crc;

  always_comb begin
    is_crc = 1'b0;
    unique case (uword_i.src)
      mbf_pkg::SRC_SLAVE:    sel_byte = slave_q;
      mbf_pkg::SRC_FUNC:     sel_byte = func_q;
      mbf_pkg::SRC_ADDR_HI:  sel_byte = addr_q[15:8];
      mbf_pkg::SRC_ADDR_LO:  sel_byte = addr_q[7:0];
      mbf_pkg::SRC_CV_HI:    sel_byte = cv_q[15:8];
      mbf_pkg::SRC_CV_LO:    sel_byte = cv_q[7:0];
      mbf_pkg::SRC_QTY_HI:   sel_byte = mbf_pkg::QtyHi;
      mbf_pkg::SRC_QTY_LO:   sel_byte = mbf_pkg::QtyLo;
      mbf_pkg::SRC_BYTE_CNT: sel_byte = mbf_pkg::ByteCount;
      mbf_pkg::SRC_CRC_LO: begin
        sel_byte = crc_q[7:0];
        is_crc   = 1'b1;
      end
      default: begin
        sel_byte = crc_q[15:8];
        is_crc   = 1'b1;
      end
    endcase
  end

  // Every body byte folds into the CRC as it is emitted.
  always_comb begin
    crc_d = crc_q;
    priority if (start_i) begin
      crc_d = mbf_pkg::CrcPreset;
    end else if (advance_i && !is_crc) begin
      crc_d = mbf_pkg::crc16_byte(crc_q, sel_byte);
    end else begin
      crc_d = crc_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    priority if (advance_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= mbf_pkg::CrcPreset;
      valid_q <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      slave_q <= slave_addr_i;
      func_q  <= function_code_i;
      addr_q  <= reg_addr_i;
      cv_q    <= count_or_value_i;
    end
    if (advance_i) begin
      byte_q <= sel_byte;
      last_q <= uword_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

FILE: design/modbus_rtu_request_framer.sv
// Modbus RTU request framer: one request in, 8 (read) or 11 (write) frame bytes out.
// The request transfer loads the step counter and the field registers, and each
// step loads the output byte register. Throughput: one byte per cycle while the
// output is not stalled; a request is taken alongside the last byte of a frame.
// Reset clears the step counter, busy flag, output valid and presets the CRC.
// Depends on mbf_pkg, mbf_if, mbf_sequencer and mbf_datapath.
module modbus_rtu_request_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbf_req_if.sink           req_i,
  mbf_byte_if.source        frame_o
);

  mbf_pkg::uword_t      uword;
  mbf_pkg::seq_status_t status;
  logic                 out_valid;
  logic                 advance;
  logic                 start;

  assign advance     = status.busy && (!out_valid || frame_o.ready);
  assign req_i.ready = !status.busy || (advance && uword.last);
  assign start       = req_i.valid && req_i.ready;

  mbf_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .mode_i    (req_i.mode),
    .advance_i (advance),
    .uword_o   (uword),
    .status_o  (status)
  );

  mbf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .slave_addr_i     (req_i.slave_addr),
    .function_code_i  (req_i.function_code),
    .reg_addr_i       (req_i.reg_addr),
    .count_or_value_i (req_i.count_or_value),
    .advance_i        (advance),
    .uword_i          (uword),
    .out_ready_i      (frame_o.ready),
    .out_valid_o      (out_valid),
    .frame_byte_o     (frame_o.frame_byte),
    .last_byte_o      (frame_o.last_byte)
  );

  assign frame_o.valid = out_valid;

  // A request transfer always starts the program at its first step.
  a_start_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> status.busy && status.pc == '0)
    else $error("request transfer did not restart the sequencer");

  // The step counter never leaves the program.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> status.pc < mbf_pkg::PcW'(mbf_pkg::ProgLen))
    else $error("step counter outside the program");

  // A request is taken during a frame only together with its final byte.
  a_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && status.busy |-> advance && uword.last)
    else $error("request taken in the middle of a frame");

  // The final byte always comes from the high CRC step.
  a_last_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && uword.last |-> uword.src == mbf_pkg::SRC_CRC_HI)
    else $error("frame closed on a non-CRC byte");

endmodule
